/* hdl/qre_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qre_pkg
// Shared widths, codes and constants of the queue rate estimator.
// ----------------------------------------------------------------------------
package qre_pkg;

    localparam int ALPHA_BITS    = 16;
    localparam int FRACTION_BITS = 8;

    // datapath widths
    localparam int MUL_A_W = 57;
    localparam int MUL_B_W = 19;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int NUM_W   = 72;
    localparam int AVG_W   = 56;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // phase of the shared divider / ewma sequence
    localparam logic [1:0] PH_ARR = 2'd0;
    localparam logic [1:0] PH_DRN = 2'd1;
    localparam logic [1:0] PH_QRY = 2'd2;

    // register indexes
    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_MINS  = 2'd1;
    localparam logic [1:0] REG_STALE = 2'd2;
    localparam logic [1:0] REG_FLOOR = 2'd3;

    // 1e9 = 625 * 3125 * 2^9, 1e6 = 15625 * 2^6
    localparam logic [MUL_B_W-1:0] K_625   = 19'd625;
    localparam logic [MUL_B_W-1:0] K_3125  = 19'd3125;
    localparam logic [MUL_B_W-1:0] K_15625 = 19'd15625;

    localparam logic [16:0] ONE_W = 17'd65536;

endpackage

/* hdl/queue_rate_estimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_rate_estimator
// EWMA monitor of queue arrival rate, drain rate and occupancy, with a
// wait estimate for queries.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_ready (command, payload_bytes,
// occupancy_bytes, timestamp_ns); one result per request leaves on
// out_valid/out_ready. Registers are written over the APB port at byte
// address 8*i (alpha, trust threshold, stale_window_ns, drain_floor_bps).
// One request is in work at a time; in_ready is high only when idle.
// A shared 57x19 multiplier and a one-bit-per-cycle restoring divider
// (72 steps) do all arithmetic under a small sequencer.
// A query takes one division; a sample updates the level average and,
// when time has passed since a previous sample, the arrival rate, then,
// if the occupancy fell below the previous level, the drain rate.
// The next request can be taken in the cycle after the result is
// delivered.
// A result is held in its output register while out_ready is low, and no
// new request is taken until it is delivered.
// Reset clears all averages and counters and loads the register defaults.
// ----------------------------------------------------------------------------
module queue_rate_estimator
    import qre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [31:0] payload_bytes,
    input  logic [31:0] occupancy_bytes,
    input  logic [63:0] timestamp_ns,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] wait_us,
    output logic [47:0] arrival_rate,
    output logic [47:0] outflow_rate,
    output logic [31:0] level_average,
    output logic        estimate_reliable
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LVL_A = 4'd1;
    localparam logic [3:0] ST_LVL_B = 4'd2;
    localparam logic [3:0] ST_S1    = 4'd3;
    localparam logic [3:0] ST_S2    = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_EA    = 4'd6;
    localparam logic [3:0] ST_EB    = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    localparam logic [6:0] DIV_LAST = 7'(NUM_W - 1);

    // configuration registers
    logic [16:0] alpha_reg;
    logic [15:0] trust_threshold_reg;
    logic [39:0] stale_reg;
    logic [39:0] floor_reg;

    // estimator state
    logic [63:0]      last_time_reg;
    logic [32:0]      prev_level_reg;
    logic [AVG_W-1:0] arrival_avg_reg;
    logic [AVG_W-1:0] drain_avg_reg;
    logic [39:0]      level_avg_reg;
    logic [31:0]      drain_samples_reg;
    logic             drain_seen_reg;
    logic [63:0]      last_drain_reg;

    // sequencer and datapath registers
    logic [3:0]        state_reg;
    logic [1:0]        phase_reg;
    logic              cmd_reg;
    logic [31:0]       pay_reg;
    logic [31:0]       occ_reg;
    logic [63:0]       now_reg;
    logic              rate_ok_reg;
    logic              drain_ok_reg;
    logic [32:0]       diff_reg;
    logic              used_reg;
    logic [63:0]       d_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [63:0]       rem_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [6:0]        cnt_reg;
    logic [PROD_W-1:0] acc_reg;

    logic [MUL_A_W-1:0] m_a;
    logic [MUL_B_W-1:0] m_b;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  sum;
    logic [16:0]        weight;
    logic [64:0]        rem_sh;
    logic               ge;
    logic [AVG_W-1:0]   rate_sat;
    logic [47:0]        wait_sat;
    logic               cfg_wr;
    logic               in_acc;
    logic               fresh;
    logic               trusted;
    logic [39:0]        floor_bps;
    logic [47:0]        floor_fx;
    logic [63:0]        since_drain;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc = in_valid & in_ready;

    // register read
    always_comb
    begin
        unique case (paddr[4:3])
            REG_ALPHA: prdata = {47'b0, alpha_reg};
            REG_MINS:  prdata = {48'b0, trust_threshold_reg};
            REG_STALE: prdata = {24'b0, stale_reg};
            REG_FLOOR: prdata = {24'b0, floor_reg};
            default:   prdata = 64'b0;
        endcase
    end

    // clamped weight
    assign weight = alpha_reg[16] ? ONE_W : alpha_reg;

    // query trust and rate selection
    assign since_drain = timestamp_ns - last_drain_reg;
    assign fresh = (last_drain_reg != 64'b0) && (timestamp_ns >= last_drain_reg)
                   && (since_drain < {24'b0, stale_reg});
    assign trusted = (drain_samples_reg >= {16'b0, trust_threshold_reg}) && drain_seen_reg
                     && fresh;
    assign floor_bps = (floor_reg == 40'b0) ? 40'd1 : floor_reg;
    assign floor_fx = {floor_bps, 8'b0};

    // shared multiplier operand select
    always_comb
    begin
        m_a = '0;
        m_b = '0;
        unique case (state_reg)
            ST_LVL_A:
            begin
                m_a = MUL_A_W'({occ_reg, 8'b0});
                m_b = MUL_B_W'(weight);
            end
            ST_LVL_B:
            begin
                m_a = MUL_A_W'(level_avg_reg);
                m_b = 19'd262144 - MUL_B_W'(weight);
            end
            ST_S1:
            begin
                priority if (phase_reg == PH_QRY)
                begin
                    m_a = MUL_A_W'(occ_reg);
                    m_b = K_15625;
                end
                else if (phase_reg == PH_DRN)
                begin
                    m_a = MUL_A_W'(diff_reg);
                    m_b = K_625;
                end
                else
                begin
                    m_a = MUL_A_W'(pay_reg);
                    m_b = K_625;
                end
            end
            ST_S2:
            begin
                m_a = acc_reg[MUL_A_W-1:0];
                m_b = K_3125;
            end
            ST_EA:
            begin
                m_a = MUL_A_W'(rate_sat);
                m_b = MUL_B_W'(weight);
            end
            ST_EB:
            begin
                m_a = MUL_A_W'((phase_reg == PH_DRN) ? drain_avg_reg : arrival_avg_reg);
                m_b = MUL_B_W'(ONE_W - weight);
            end
            default:
            begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(m_a) * PROD_W'(m_b);
    assign sum  = acc_reg + prod;

    // divider step
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign ge = rem_sh >= {1'b0, d_reg};

    // saturation of the quotient
    assign rate_sat = (q_reg > NUM_W'({AVG_W{1'b1}})) ? {AVG_W{1'b1}} : q_reg[AVG_W-1:0];
    assign wait_sat = (q_reg > NUM_W'({48{1'b1}})) ? {48{1'b1}} : q_reg[47:0];

    // result fields
    assign out_valid = (state_reg == ST_OUT);
    assign wait_us = (cmd_reg == CMD_QUERY) ? wait_sat : 48'b0;
    assign estimate_reliable = (cmd_reg == CMD_QUERY) & used_reg;
    assign arrival_rate = arrival_avg_reg[AVG_W-1:FRACTION_BITS];
    assign outflow_rate = drain_avg_reg[AVG_W-1:FRACTION_BITS];
    assign level_average = level_avg_reg[39:FRACTION_BITS];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg           <= 17'd8192;
            trust_threshold_reg <= 16'd8;
            stale_reg           <= 40'd100000000;
            floor_reg           <= 40'd1000000;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                REG_ALPHA: alpha_reg           <= pwdata[16:0];
                REG_MINS:  trust_threshold_reg <= pwdata[15:0];
                REG_STALE: stale_reg           <= pwdata[39:0];
                REG_FLOOR: floor_reg           <= pwdata[39:0];
                default:   alpha_reg           <= alpha_reg;
            endcase
        end
    end

    // sequencer and state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            phase_reg         <= PH_ARR;
            cmd_reg           <= CMD_SAMPLE;
            last_time_reg     <= '0;
            prev_level_reg    <= '0;
            arrival_avg_reg   <= '0;
            drain_avg_reg     <= '0;
            level_avg_reg     <= '0;
            drain_samples_reg <= '0;
            drain_seen_reg    <= 1'b0;
            last_drain_reg    <= '0;
            used_reg          <= 1'b0;
            rate_ok_reg       <= 1'b0;
            drain_ok_reg      <= 1'b0;
            cnt_reg           <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        cmd_reg <= command;
                        pay_reg <= payload_bytes;
                        occ_reg <= occupancy_bytes;
                        now_reg <= timestamp_ns;
                        if (command == CMD_SAMPLE)
                        begin
                            rate_ok_reg  <= (last_time_reg != 64'b0)
                                            && (timestamp_ns > last_time_reg);
                            drain_ok_reg <= {1'b0, occupancy_bytes} < prev_level_reg;
                            diff_reg     <= prev_level_reg - {1'b0, occupancy_bytes};
                            prev_level_reg <= {1'b0, occupancy_bytes}
                                              + {1'b0, payload_bytes};
                            last_time_reg <= timestamp_ns;
                            d_reg     <= timestamp_ns - last_time_reg;
                            used_reg  <= 1'b0;
                            state_reg <= ST_LVL_A;
                        end
                        else
                        begin
                            if (trusted && (drain_avg_reg > {8'b0, floor_fx}))
                            begin
                                d_reg    <= {8'b0, drain_avg_reg};
                                used_reg <= (occupancy_bytes != 32'b0);
                            end
                            else
                            begin
                                d_reg    <= {16'b0, floor_fx};
                                used_reg <= 1'b0;
                            end
                            phase_reg <= PH_QRY;
                            state_reg <= ST_S1;
                        end
                    end
                end
                ST_LVL_A:
                begin
                    acc_reg   <= prod;
                    state_reg <= ST_LVL_B;
                end
                ST_LVL_B:
                begin
                    level_avg_reg <= sum[57:18];
                    phase_reg     <= PH_ARR;
                    state_reg     <= rate_ok_reg ? ST_S1 : ST_OUT;
                end
                ST_S1:
                begin
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    if (phase_reg == PH_QRY)
                    begin
                        num_reg   <= {12'b0, prod[45:0], 14'b0};
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        acc_reg   <= prod;
                        state_reg <= ST_S2;
                    end
                end
                ST_S2:
                begin
                    num_reg   <= {prod[54:0], 17'b0};
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg <= ge ? 64'(rem_sh - {1'b0, d_reg}) : rem_sh[63:0];
                    q_reg   <= {q_reg[NUM_W-2:0], ge};
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == DIV_LAST)
                        state_reg <= (phase_reg == PH_QRY) ? ST_OUT : ST_EA;
                end
                ST_EA:
                begin
                    acc_reg   <= prod;
                    state_reg <= ST_EB;
                end
                ST_EB:
                begin
                    if (phase_reg == PH_DRN)
                    begin
                        drain_avg_reg  <= sum[71:16];
                        drain_seen_reg <= 1'b1;
                        last_drain_reg <= now_reg;
                        if (drain_samples_reg != 32'hffff_ffff)
                            drain_samples_reg <= drain_samples_reg + 32'd1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        arrival_avg_reg <= sum[71:16];
                        phase_reg       <= PH_DRN;
                        state_reg       <= drain_ok_reg ? ST_S1 : ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
